>>> rtl/glu_pkg.sv
// Shared types and constants for the GCD/LCM unit.
package glu_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int FIELD_IN_W    = 16;
    localparam int DIV_RES_W     = 16;
    localparam int MUL_RES_W     = 32;
    localparam int SHIFT_W       = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;
    localparam int COUNT_W       = $clog2(OPERAND_WIDTH + 1);

    typedef struct packed {
        logic [FIELD_IN_W-1:0] first_operand;
        logic [FIELD_IN_W-1:0] second_operand;
    } op_t;

    typedef struct packed {
        logic [DIV_RES_W-1:0] divisor_result;
        logic [MUL_RES_W-1:0] multiple_result;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_MUL,
        S_OUT
    } glu_state_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul;
        logic out_load;
    } glu_cmd_t;

    typedef struct packed {
        logic zero;
        logic gcd_equal;
        logic div_done;
    } glu_sts_t;

endpackage

>>> rtl/glu_ctrl.sv
// Controller state machine for the GCD/LCM unit.
module glu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_stall,
    output logic              res_valid,
    input  logic              res_stall,
    input  glu_pkg::glu_sts_t sts,
    output glu_pkg::glu_cmd_t cmd
);

    glu_pkg::glu_state_t state_reg;
    glu_pkg::glu_state_t state_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic                out_free;

    // output register can take a new result when empty or being drained
    assign out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= glu_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            glu_pkg::S_IDLE:
            begin
                if (op_valid)
                    state_next = glu_pkg::S_GCD;
            end
            glu_pkg::S_GCD:
            begin
                priority if (sts.zero)
                    state_next = glu_pkg::S_OUT;
                else if (sts.gcd_equal)
                    state_next = glu_pkg::S_DIV;
            end
            glu_pkg::S_DIV:
            begin
                if (sts.div_done)
                    state_next = glu_pkg::S_MUL;
            end
            glu_pkg::S_MUL:
            begin
                state_next = glu_pkg::S_OUT;
            end
            glu_pkg::S_OUT:
            begin
                if (out_free)
                    state_next = glu_pkg::S_IDLE;
            end
            default:
            begin
                state_next = glu_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            glu_pkg::S_IDLE:
            begin
                cmd.load = op_valid;
            end
            glu_pkg::S_GCD:
            begin
                cmd.gcd_step = !sts.zero && !sts.gcd_equal;
                cmd.div_init = !sts.zero && sts.gcd_equal;
            end
            glu_pkg::S_DIV:
            begin
                cmd.div_step = !sts.div_done;
            end
            glu_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            glu_pkg::S_OUT:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
            res_valid_next = 1'b1;
        else if (res_stall)
            res_valid_next = res_valid_reg;
        else
            res_valid_next = 1'b0;
    end

    assign op_stall  = (state_reg != glu_pkg::S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

>>> rtl/glu_datapath.sv
// Datapath: binary GCD, restoring divider for a/gcd, multiplier, output register.
module glu_datapath (
    input  logic              clk,
    input  glu_pkg::op_t      op_data,
    input  glu_pkg::glu_cmd_t cmd,
    output glu_pkg::glu_sts_t sts,
    output glu_pkg::res_t     res_data
);

    localparam int W = glu_pkg::OPERAND_WIDTH;

    logic [W-1:0]                  a_reg;
    logic [W-1:0]                  b_reg;
    logic [W-1:0]                  x_reg;
    logic [W-1:0]                  x_next;
    logic [W-1:0]                  y_reg;
    logic [W-1:0]                  y_next;
    logic [glu_pkg::SHIFT_W-1:0]   k_reg;
    logic [glu_pkg::SHIFT_W-1:0]   k_next;
    logic [W-1:0]                  g_reg;
    logic [W-1:0]                  rem_reg;
    logic [W-1:0]                  rem_next;
    logic [W-1:0]                  quo_reg;
    logic [W-1:0]                  quo_next;
    logic [glu_pkg::COUNT_W-1:0]   cnt_reg;
    logic [2*W-1:0]                prod_reg;
    logic                          zero_reg;
    glu_pkg::res_t                 res_reg;

    logic [W-1:0]                  x_in;
    logic [W-1:0]                  y_in;
    logic [W:0]                    rem_shift;
    logic [W:0]                    trial;

    assign x_in = W'(op_data.first_operand);
    assign y_in = W'(op_data.second_operand);

    // one binary GCD step: strip common twos, strip lone twos, else halve the difference
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        k_next = k_reg;
        priority if (!x_reg[0] && !y_reg[0])
        begin
            x_next = x_reg >> 1;
            y_next = y_reg >> 1;
            k_next = k_reg + 1'b1;
        end
        else if (!x_reg[0])
            x_next = x_reg >> 1;
        else if (!y_reg[0])
            y_next = y_reg >> 1;
        else if (x_reg > y_reg)
            x_next = (x_reg - y_reg) >> 1;
        else
            y_next = (y_reg - x_reg) >> 1;
    end

    // restoring division step, quotient bits shift in where dividend bits leave
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign trial     = rem_shift - {1'b0, g_reg};

    always_comb
    begin
        if (trial[W])
        begin
            rem_next = rem_shift[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
        else
        begin
            rem_next = trial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= x_in;
            b_reg    <= y_in;
            x_reg    <= x_in;
            y_reg    <= y_in;
            k_reg    <= '0;
            zero_reg <= (x_in == '0) || (y_in == '0);
        end
        if (cmd.gcd_step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            k_reg <= k_next;
        end
        if (cmd.div_init)
        begin
            g_reg   <= x_reg << k_reg;
            rem_reg <= '0;
            quo_reg <= a_reg;
            cnt_reg <= glu_pkg::COUNT_W'(W);
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.mul)
            prod_reg <= quo_reg * b_reg;
        if (cmd.out_load)
        begin
            if (zero_reg)
                res_reg <= '0;
            else
            begin
                res_reg.divisor_result  <= glu_pkg::DIV_RES_W'(g_reg);
                res_reg.multiple_result <= glu_pkg::MUL_RES_W'(prod_reg);
            end
        end
    end

    assign sts.zero      = zero_reg;
    assign sts.gcd_equal = (x_reg == y_reg);
    assign sts.div_done  = (cnt_reg == '0);
    assign res_data      = res_reg;

endmodule

>>> rtl/gcd_lcm_unit.sv
// Top level of the GCD/LCM unit: controller plus datapath.
//
// Operand channel op_*: one transfer carries first_operand and second_operand.
// Result channel res_*: one transfer per operand pair, carrying the greatest
// common divisor and least common multiple; both are zero if an operand is zero.
// Items are processed one at a time. After a transfer op_stall stays high until
// the result is moved into the output register. Steps per item: capture,
// binary GCD steps, divider setup, restoring divide a/gcd (16 steps, then a
// done check), multiply, output load; a zero operand skips straight to
// output. The binary GCD loop and the one-bit-per-cycle divider are iterative.
// The output register holds a finished result while res_stall is high; the
// next operand pair can be taken as soon as the result is loaded there.
// Reset (rst_n low, asynchronous) returns the controller to idle and clears
// res_valid; nothing else is kept between items.
module gcd_lcm_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_stall,
    input  glu_pkg::op_t  op_data,
    output logic          res_valid,
    input  logic          res_stall,
    output glu_pkg::res_t res_data
);

    glu_pkg::glu_cmd_t cmd;
    glu_pkg::glu_sts_t sts;

    glu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    glu_datapath u_datapath (
        .clk      (clk),
        .op_data  (op_data),
        .cmd      (cmd),
        .sts      (sts),
        .res_data (res_data)
    );

endmodule

>>> rtl/glu_checker.sv
// Port-level checks for the GCD/LCM unit, bound to the top level.
module glu_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          op_valid,
    input logic          op_stall,
    input logic          res_valid,
    input logic          res_stall,
    input glu_pkg::res_t res_data
);

    // one item at a time: a transfer closes the operand channel next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op_stall) |=> op_stall)
        else $error("operand channel open right after a transfer");

    a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.divisor_result == '0)) |->
            (res_data.multiple_result == '0))
        else $error("zero divisor with nonzero multiple");

    a_nonzero_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.divisor_result != '0)) |->
            (res_data.multiple_result != '0))
        else $error("nonzero divisor with zero multiple");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
        else $error("stalled result changed");

endmodule

bind gcd_lcm_unit glu_checker u_glu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

>>> tb/tb_gcd_lcm_unit.sv
// Self-checking testbench for gcd_lcm_unit: directed corners, random operand mixes, back-pressure.
module tb_gcd_lcm_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 80;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          op_valid = 1'b0;
    logic          op_stall;
    glu_pkg::op_t  op_data = '0;
    logic          res_valid;
    logic          res_stall = 1'b0;
    glu_pkg::res_t res_data;

    glu_pkg::res_t pending_results[$];
    int   errors = 0;
    bit   gaps_on = 1'b1;
    int   hold_request = 0;
    int   hold_left = 0;
    int   stuck_cycles = 0;

    gcd_lcm_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Euclid on the operand pair; lcm = (a / gcd) * b always fits 32 bits at 16-bit operands.
    function automatic glu_pkg::res_t gcd_lcm_of(glu_pkg::op_t item);
        logic [31:0]   x;
        logic [31:0]   y;
        logic [31:0]   r;
        glu_pkg::res_t res;
        x = 32'(item.first_operand);
        y = 32'(item.second_operand);
        res = '0;
        if (x != 0 && y != 0)
        begin
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            res.divisor_result = glu_pkg::DIV_RES_W'(x);
            res.multiple_result = (32'(item.first_operand) / x) * 32'(item.second_operand);
        end
        return res;
    endfunction

    function automatic glu_pkg::op_t random_pair();
        glu_pkg::op_t item;
        int unsigned  g;
        int unsigned  pick;
        item.first_operand = 16'($urandom);
        item.second_operand = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // full-range operands, left as drawn
        end
        else if (pick < 65)
        begin
            // shared factor so the gcd is nontrivial
            g = $urandom_range(2, 300);
            item.first_operand = 16'(g * $urandom_range(1, 65535 / g));
            item.second_operand = 16'(g * $urandom_range(1, 65535 / g));
        end
        else if (pick < 75)
        begin
            item.first_operand = 16'($urandom_range(1, 64));
            item.second_operand = 16'($urandom_range(1, 64));
        end
        else if (pick < 82)
        begin
            item.first_operand = 16'($urandom_range(1, 65535));
            item.second_operand = item.first_operand;
        end
        else if (pick < 88)
        begin
            item.first_operand = 16'(1) << $urandom_range(15);
        end
        else if (pick < 94)
        begin
            if ($urandom_range(1) == 0)
                item.first_operand = '0;
            else
                item.second_operand = '0;
        end
        else
        begin
            item.first_operand = 16'(65535 - $urandom_range(40));
            item.second_operand = 16'(65535 - $urandom_range(40));
        end
        return item;
    endfunction

    // Called just after a falling edge; returns just after the falling edge past the transfer.
    task automatic send_pair(input glu_pkg::op_t item);
        while (gaps_on && $urandom_range(99) < 11)
        begin
            op_valid = 1'b0;
            @(negedge clk);
        end
        op_valid = 1'b1;
        op_data = item;
        @(posedge clk);
        while (op_stall)
            @(posedge clk);
        pending_results.push_back(gcd_lcm_of(item));
        @(negedge clk);
        op_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        glu_pkg::op_t corners[18];
        corners = '{
            '{16'h0000, 16'h0000}, '{16'h0000, 16'h1234}, '{16'hFFFF, 16'h0000},
            '{16'h0001, 16'h0001}, '{16'hFFFF, 16'hFFFF}, '{16'h0001, 16'hFFFF},
            '{16'hFFFF, 16'h0001}, '{16'h04D2, 16'h04D2}, '{16'hFFFF, 16'hFFFE},
            '{16'h8000, 16'h8000}, '{16'h8000, 16'h4000}, '{16'h000C, 16'h0012},
            '{16'hFFFE, 16'h7FFF}, '{16'hFFF1, 16'hFFEF}, '{16'hAAAA, 16'h5555},
            '{16'h8000, 16'h0001}, '{16'hFFFF, 16'h0101}, '{16'h7FFF, 16'h8000}
        };
        foreach (corners[i])
            send_pair(corners[i]);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_pair(random_pair());
    endtask

    task automatic test_full_rate(input int count);
        gaps_on = 1'b0;
        repeat (count)
            send_pair(random_pair());
        gaps_on = 1'b1;
    endtask

    // Receiver holds off while items keep coming, so the input side backs up.
    task automatic test_output_hold();
        hold_request = HOLD_CYCLES;
        repeat (12)
            send_pair(random_pair());
    endtask

    // Sender stops until every outstanding result is back, then resumes.
    task automatic test_drain_pause();
        repeat (40)
            send_pair(random_pair());
        wait_drained();
        repeat (40)
            send_pair(random_pair());
    endtask

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            res_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else
            res_stall = gaps_on && ($urandom_range(99) < 11);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing outstanding, actual gcd %0d lcm %0d",
                         $time, res_data.divisor_result, res_data.multiple_result);
                errors++;
            end
            else
            begin
                glu_pkg::res_t want;
                want = pending_results.pop_front();
                if (res_data.divisor_result !== want.divisor_result)
                begin
                    $display("%0t: divisor_result mismatch, expected %0d, actual %0d",
                             $time, want.divisor_result, res_data.divisor_result);
                    errors++;
                end
                if (res_data.multiple_result !== want.multiple_result)
                begin
                    $display("%0t: multiple_result mismatch, expected %0d, actual %0d",
                             $time, want.multiple_result, res_data.multiple_result);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((op_valid && !op_stall) || (res_valid && !res_stall))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("gcd_lcm_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_mix(600);
        test_output_hold();
        test_full_rate(300);
        test_drain_pause();
        test_random_mix(170);

        wait_drained();
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("gcd_lcm_unit regression: pass");
        else
            $display("gcd_lcm_unit regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/glu_pkg.sv
rtl/glu_ctrl.sv
rtl/glu_datapath.sv
rtl/gcd_lcm_unit.sv
rtl/glu_checker.sv
tb/tb_gcd_lcm_unit.sv
